[hw/rtl/lsds_pkg.sv]
`default_nettype none
package lsds_pkg;

  localparam int CHANNELS = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHANNELS-1:0] CHAN_ALL = {CHANNELS{1'b1}};

  localparam logic [CHANNELS-1:0] PAT_RIGHT        = 5'b00010;
  localparam logic [CHANNELS-1:0] PAT_SLIGHT_RIGHT = 5'b11001;
  localparam logic [CHANNELS-1:0] PAT_LEFT         = 5'b10111;
  localparam logic [CHANNELS-1:0] PAT_SLIGHT_LEFT  = 5'b10011;
  localparam logic [CHANNELS-1:0] PAT_STRAIGHT     = 5'b11011;

  localparam logic [15:0] RST_LIGHT_THRESHOLD = 16'h0350;
  localparam logic [15:0] RST_TIMEOUT_COUNT   = 16'h0730;
  localparam logic [7:0]  RST_BASE_SPEED      = 8'd44;
  localparam logic [7:0]  RST_GENTLE_OFFSET   = 8'd2;
  localparam logic [7:0]  RST_SHARP_OFFSET    = 8'd10;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_TICK   = 2'd1,
    OP_SAMPLE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ACT_BRAKE        = 3'd0,
    ACT_STRAIGHT     = 3'd1,
    ACT_SLIGHT_LEFT  = 3'd2,
    ACT_SLIGHT_RIGHT = 3'd3,
    ACT_LEFT         = 3'd4,
    ACT_RIGHT        = 3'd5
  } act_t;

  typedef enum logic [2:0] {
    REG_LIGHT_THRESHOLD = 3'd0,
    REG_TIMEOUT_COUNT   = 3'd1,
    REG_BASE_SPEED      = 3'd2,
    REG_GENTLE_OFFSET   = 3'd3,
    REG_SHARP_OFFSET    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] light_threshold;
    logic [15:0] timeout_count;
    logic [7:0]  base_speed;
    logic [7:0]  gentle_offset;
    logic [7:0]  sharp_offset;
  } cfg_t;

  typedef struct packed {
    logic [CHANNELS-1:0] pattern;
    logic                timed_out;
  } reading_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage
`default_nettype wire

[hw/rtl/line_sensor_decay_steering.sv]
// Line sensor reader and steering controller.
// Input channel: in_valid, in_stall, in_opcode and in_pin_levels. A word is taken at
// each rising edge with in_valid high and in_stall low. Opcode start opens a
// measurement, tick advances the decay count, and pin sample marks changed channels.
// Output channel: out_valid, out_stall and the pattern, action, duty and timeout
// fields. One word leaves for each finished measurement.
// Configuration: cfg_valid, cfg_ready, cfg_index and cfg_data. cfg_ready is always
// high, so a write takes effect at any edge with cfg_valid high. Write only while idle.
// Throughput is one input word per cycle while in_stall is low. A word that
// finishes a measurement is written into the queue at the edge that accepts it,
// and out_valid rises when the steering stage pops it into the output register.
// When the receiver stalls, the output word holds and the queue between the front
// and the steering stage fills. in_stall rises once the queue is full, and falls
// once a word is popped after the receiver releases the output.
// Reset clears the measurement state and the queue, drops out_valid and loads the
// configuration registers with their default values.
`default_nettype none
module line_sensor_decay_steering #(
  parameter int QDEPTH = lsds_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic [lsds_pkg::CHANNELS-1:0] in_pin_levels,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [lsds_pkg::CHANNELS-1:0]      out_line_pattern,
  output logic [2:0]                         out_steer_action,
  output logic [7:0]                         out_left_duty,
  output logic [7:0]                         out_right_duty,
  output logic                               out_timed_out,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [15:0]                   cfg_data
);
  import lsds_pkg::*;

  cfg_t      cfg_r;
  q_status_t q_status;
  reading_t  push_data, pop_data;
  logic      push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_threshold <= RST_LIGHT_THRESHOLD;
      cfg_r.timeout_count   <= RST_TIMEOUT_COUNT;
      cfg_r.base_speed      <= RST_BASE_SPEED;
      cfg_r.gentle_offset   <= RST_GENTLE_OFFSET;
      cfg_r.sharp_offset    <= RST_SHARP_OFFSET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_LIGHT_THRESHOLD: cfg_r.light_threshold <= cfg_data;
        REG_TIMEOUT_COUNT:   cfg_r.timeout_count   <= cfg_data;
        REG_BASE_SPEED:      cfg_r.base_speed      <= cfg_data[7:0];
        REG_GENTLE_OFFSET:   cfg_r.gentle_offset   <= cfg_data[7:0];
        REG_SHARP_OFFSET:    cfg_r.sharp_offset    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  lsds_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_opcode     (in_opcode),
    .in_pin_levels (in_pin_levels),
    .cfg           (cfg_r),
    .q_status      (q_status),
    .in_stall      (in_stall),
    .push          (push),
    .push_data     (push_data)
  );

  lsds_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  lsds_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_status         (q_status),
    .q_data           (pop_data),
    .pop              (pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_line_pattern (out_line_pattern),
    .out_steer_action (out_steer_action),
    .out_left_duty    (out_left_duty),
    .out_right_duty   (out_right_duty),
    .out_timed_out    (out_timed_out)
  );

endmodule
`default_nettype wire

[hw/rtl/lsds_front.sv]
`default_nettype none
module lsds_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [1:0]                in_opcode,
  input  wire logic [lsds_pkg::CHANNELS-1:0] in_pin_levels,
  input  wire lsds_pkg::cfg_t            cfg,
  input  wire lsds_pkg::q_status_t       q_status,
  output logic                           in_stall,
  output logic                           push,
  output lsds_pkg::reading_t             push_data
);
  import lsds_pkg::*;

  logic [CHANNELS-1:0] prev_pins_r, prev_pins_nxt;
  logic [CHANNELS-1:0] light_mask_r, light_mask_nxt;
  logic [CHANNELS-1:0] read_mask_r, read_mask_nxt;
  logic [15:0]         elapsed_r, elapsed_nxt;
  logic                busy_r, busy_nxt;
  logic                accept;
  logic [15:0]         elapsed_inc;
  logic [CHANNELS-1:0] changed;

  assign in_stall    = q_status.full;
  assign accept      = in_valid && !q_status.full;
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign changed     = in_pin_levels ^ prev_pins_r;

  always_comb begin
    prev_pins_nxt      = prev_pins_r;
    light_mask_nxt     = light_mask_r;
    read_mask_nxt      = read_mask_r;
    elapsed_nxt        = elapsed_r;
    busy_nxt           = busy_r;
    push               = 1'b0;
    push_data.pattern  = light_mask_r;
    push_data.timed_out = 1'b0;
    if (accept) begin
      case (op_t'(in_opcode))
        OP_START: begin
          prev_pins_nxt  = CHAN_ALL;
          light_mask_nxt = '0;
          read_mask_nxt  = '0;
          elapsed_nxt    = '0;
          busy_nxt       = 1'b1;
        end
        OP_TICK: begin
          if (busy_r) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= cfg.timeout_count) begin
              read_mask_nxt       = CHAN_ALL;
              busy_nxt            = 1'b0;
              push                = 1'b1;
              push_data.timed_out = 1'b1;
            end
          end
        end
        OP_SAMPLE: begin
          if (busy_r) begin
            prev_pins_nxt = in_pin_levels;
            if (elapsed_r < cfg.light_threshold) begin
              light_mask_nxt = light_mask_r | changed;
            end
            read_mask_nxt = read_mask_r | changed;
            if (read_mask_nxt == CHAN_ALL) begin
              busy_nxt          = 1'b0;
              push              = 1'b1;
              push_data.pattern = light_mask_nxt;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pins_r  <= CHAN_ALL;
      light_mask_r <= '0;
      read_mask_r  <= '0;
      elapsed_r    <= '0;
      busy_r       <= 1'b0;
    end else begin
      prev_pins_r  <= prev_pins_nxt;
      light_mask_r <= light_mask_nxt;
      read_mask_r  <= read_mask_nxt;
      elapsed_r    <= elapsed_nxt;
      busy_r       <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lsds_queue.sv]
`default_nettype none
module lsds_queue #(
  parameter int QDEPTH = lsds_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire lsds_pkg::reading_t  push_data,
  input  wire logic                pop,
  output lsds_pkg::reading_t       pop_data,
  output lsds_pkg::q_status_t      status
);
  import lsds_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  reading_t       mem_r [QDEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CW'(QDEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lsds_back.sv]
`default_nettype none
module lsds_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lsds_pkg::cfg_t                cfg,
  input  wire lsds_pkg::q_status_t           q_status,
  input  wire lsds_pkg::reading_t            q_data,
  output logic                               pop,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic [lsds_pkg::CHANNELS-1:0]      out_line_pattern,
  output logic [2:0]                         out_steer_action,
  output logic [7:0]                         out_left_duty,
  output logic [7:0]                         out_right_duty,
  output logic                               out_timed_out
);
  import lsds_pkg::*;

  logic                valid_r;
  logic [CHANNELS-1:0] pattern_r;
  act_t                action_r, action_nxt;
  logic [7:0]          left_r, left_nxt;
  logic [7:0]          right_r, right_nxt;
  logic                timed_out_r;
  logic [8:0]          sum_gentle, sum_sharp;
  logic [7:0]          add_gentle, add_sharp, sub_gentle, sub_sharp;

  assign pop = !q_status.empty && (!valid_r || !out_stall);

  assign sum_gentle = {1'b0, cfg.base_speed} + {1'b0, cfg.gentle_offset};
  assign sum_sharp  = {1'b0, cfg.base_speed} + {1'b0, cfg.sharp_offset};
  assign add_gentle = sum_gentle[8] ? 8'hFF : sum_gentle[7:0];
  assign add_sharp  = sum_sharp[8] ? 8'hFF : sum_sharp[7:0];
  assign sub_gentle = (cfg.base_speed > cfg.gentle_offset) ?
                      cfg.base_speed - cfg.gentle_offset : 8'd0;
  assign sub_sharp  = (cfg.base_speed > cfg.sharp_offset) ?
                      cfg.base_speed - cfg.sharp_offset : 8'd0;

  always_comb begin
    action_nxt = ACT_BRAKE;
    left_nxt   = 8'd0;
    right_nxt  = 8'd0;
    case (q_data.pattern)
      PAT_RIGHT: begin
        action_nxt = ACT_RIGHT;
        left_nxt   = sub_sharp;
        right_nxt  = add_sharp;
      end
      PAT_SLIGHT_RIGHT: begin
        action_nxt = ACT_SLIGHT_RIGHT;
        left_nxt   = sub_gentle;
        right_nxt  = add_gentle;
      end
      PAT_LEFT: begin
        action_nxt = ACT_LEFT;
        left_nxt   = add_sharp;
        right_nxt  = sub_sharp;
      end
      PAT_SLIGHT_LEFT: begin
        action_nxt = ACT_SLIGHT_LEFT;
        left_nxt   = add_gentle;
        right_nxt  = sub_gentle;
      end
      PAT_STRAIGHT: begin
        action_nxt = ACT_STRAIGHT;
        left_nxt   = cfg.base_speed;
        right_nxt  = cfg.base_speed;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pattern_r   <= q_data.pattern;
      action_r    <= action_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      timed_out_r <= q_data.timed_out;
    end
  end

  assign out_valid        = valid_r;
  assign out_line_pattern = pattern_r;
  assign out_steer_action = action_r;
  assign out_left_duty    = left_r;
  assign out_right_duty   = right_r;
  assign out_timed_out    = timed_out_r;

endmodule
`default_nettype wire

[hw/rtl/lsds_checker.sv]
`default_nettype none
module lsds_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [lsds_pkg::CHANNELS-1:0] out_line_pattern,
  input wire logic [2:0]                    out_steer_action,
  input wire logic [7:0]                    out_left_duty,
  input wire logic [7:0]                    out_right_duty,
  input wire logic                          out_timed_out
);
  import lsds_pkg::*;

  a_reset_clears_valid: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_line_pattern)
      && $stable(out_steer_action) && $stable(out_left_duty)
      && $stable(out_right_duty) && $stable(out_timed_out))
    else $error("stalled output word changed");

  a_brake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_steer_action == ACT_BRAKE |-> out_left_duty == 8'd0
      && out_right_duty == 8'd0)
    else $error("brake with nonzero duty");

  a_straight_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_steer_action == ACT_STRAIGHT |-> out_left_duty == out_right_duty
      && out_line_pattern == PAT_STRAIGHT)
    else $error("straight with uneven duties or wrong pattern");

  a_turn_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_steer_action == ACT_LEFT || out_steer_action == ACT_SLIGHT_LEFT)
      |-> out_left_duty >= out_right_duty)
    else $error("left turn with left duty below right duty");

endmodule

bind line_sensor_decay_steering lsds_checker u_lsds_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_line_pattern (out_line_pattern),
  .out_steer_action (out_steer_action),
  .out_left_duty    (out_left_duty),
  .out_right_duty   (out_right_duty),
  .out_timed_out    (out_timed_out)
);
`default_nettype wire

[tb/steering_checker.sv]
`timescale 1ns / 1ps
module steering_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [lsds_pkg::CHANNELS-1:0] in_pin_levels,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [lsds_pkg::CHANNELS-1:0] out_line_pattern,
  input  logic [2:0]                    out_steer_action,
  input  logic [7:0]                    out_left_duty,
  input  logic [7:0]                    out_right_duty,
  input  logic                          out_timed_out,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  output int                            mismatches,
  output int                            awaiting
);
  import lsds_pkg::*;

  typedef struct packed {
    logic [CHANNELS-1:0] pattern;
    act_t                action;
    logic [7:0]          left_duty;
    logic [7:0]          right_duty;
    logic                timed_out;
  } steer_word_t;

  cfg_t                settings;
  logic [CHANNELS-1:0] last_pins;
  logic [CHANNELS-1:0] light_seen;
  logic [CHANNELS-1:0] read_seen;
  logic [15:0]         decay_count;
  logic                measuring;
  steer_word_t         steer_expected[$];

  function automatic logic [7:0] duty_plus(logic [7:0] a, logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[8] ? 8'hFF : sum[7:0];
  endfunction

  function automatic logic [7:0] duty_minus(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : 8'd0;
  endfunction

  function automatic steer_word_t steer_for(logic [CHANNELS-1:0] pat, logic by_timeout);
    steer_word_t w;
    logic [7:0]  base;
    base = settings.base_speed;
    w.pattern = pat;
    w.timed_out = by_timeout;
    w.action = ACT_BRAKE;
    w.left_duty = 8'd0;
    w.right_duty = 8'd0;
    case (pat)
      PAT_RIGHT: begin
        w.action = ACT_RIGHT;
        w.left_duty = duty_minus(base, settings.sharp_offset);
        w.right_duty = duty_plus(base, settings.sharp_offset);
      end
      PAT_SLIGHT_RIGHT: begin
        w.action = ACT_SLIGHT_RIGHT;
        w.left_duty = duty_minus(base, settings.gentle_offset);
        w.right_duty = duty_plus(base, settings.gentle_offset);
      end
      PAT_LEFT: begin
        w.action = ACT_LEFT;
        w.left_duty = duty_plus(base, settings.sharp_offset);
        w.right_duty = duty_minus(base, settings.sharp_offset);
      end
      PAT_SLIGHT_LEFT: begin
        w.action = ACT_SLIGHT_LEFT;
        w.left_duty = duty_plus(base, settings.gentle_offset);
        w.right_duty = duty_minus(base, settings.gentle_offset);
      end
      PAT_STRAIGHT: begin
        w.action = ACT_STRAIGHT;
        w.left_duty = base;
        w.right_duty = base;
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic flag(string field, int got, int want);
    mismatches++;
    $display("%0t: %s got %0d, expected %0d", $time, field, got, want);
  endtask

  task automatic finish_measurement(logic by_timeout);
    steer_expected.push_back(steer_for(light_seen, by_timeout));
    measuring = 1'b0;
  endtask

  task automatic advance(logic [1:0] op, logic [CHANNELS-1:0] pins);
    logic [CHANNELS-1:0] changed;
    changed = pins ^ last_pins;
    if (op == OP_START) begin
      light_seen = '0;
      read_seen = '0;
      decay_count = '0;
      last_pins = CHAN_ALL;
      measuring = 1'b1;
    end else if (measuring && op == OP_TICK) begin
      if (decay_count != 16'hFFFF) begin
        decay_count = decay_count + 16'd1;
      end
      if (decay_count >= settings.timeout_count) begin
        read_seen = CHAN_ALL;
        finish_measurement(1'b1);
      end
    end else if (measuring && op == OP_SAMPLE) begin
      last_pins = pins;
      if (decay_count < settings.light_threshold) begin
        light_seen = light_seen | changed;
      end
      read_seen = read_seen | changed;
      if (read_seen == CHAN_ALL) begin
        finish_measurement(1'b0);
      end
    end
  endtask

  task automatic check_word();
    steer_word_t want;
    if (steer_expected.size() == 0) begin
      flag("word with nothing expected, line_pattern", int'(out_line_pattern), 0);
    end else begin
      want = steer_expected.pop_front();
      if (out_line_pattern !== want.pattern) begin
        flag("line_pattern", int'(out_line_pattern), int'(want.pattern));
      end
      if (out_steer_action !== want.action) begin
        flag("steer_action", int'(out_steer_action), int'(want.action));
      end
      if (out_left_duty !== want.left_duty) begin
        flag("left_duty", int'(out_left_duty), int'(want.left_duty));
      end
      if (out_right_duty !== want.right_duty) begin
        flag("right_duty", int'(out_right_duty), int'(want.right_duty));
      end
      if (out_timed_out !== want.timed_out) begin
        flag("timed_out", int'(out_timed_out), int'(want.timed_out));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      settings.light_threshold = RST_LIGHT_THRESHOLD;
      settings.timeout_count = RST_TIMEOUT_COUNT;
      settings.base_speed = RST_BASE_SPEED;
      settings.gentle_offset = RST_GENTLE_OFFSET;
      settings.sharp_offset = RST_SHARP_OFFSET;
      last_pins = CHAN_ALL;
      light_seen = '0;
      read_seen = '0;
      decay_count = '0;
      measuring = 1'b0;
      steer_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LIGHT_THRESHOLD: settings.light_threshold = cfg_data;
          REG_TIMEOUT_COUNT:   settings.timeout_count = cfg_data;
          REG_BASE_SPEED:      settings.base_speed = cfg_data[7:0];
          REG_GENTLE_OFFSET:   settings.gentle_offset = cfg_data[7:0];
          REG_SHARP_OFFSET:    settings.sharp_offset = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        check_word();
      end
      if (in_valid && !in_stall) begin
        advance(in_opcode, in_pin_levels);
      end
    end
    awaiting = steer_expected.size();
  end

endmodule

[tb/line_sensor_decay_steering_tb.sv]
`timescale 1ns / 1ps
module line_sensor_decay_steering_tb;
  import lsds_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int RANDOM_WORDS = 1350;
  localparam int LIMIT_NS = 2_000_000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_opcode = OP_START;
  logic [CHANNELS-1:0] in_pin_levels = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CHANNELS-1:0] out_line_pattern;
  logic [2:0]          out_steer_action;
  logic [7:0]          out_left_duty;
  logic [7:0]          out_right_duty;
  logic                out_timed_out;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;
  logic [31:0]         mismatches;
  logic [31:0]         awaiting;

  logic                idle_on = 1'b1;
  logic                quiet = 1'b0;
  int                  stall_left = 0;
  int                  word_count = 0;
  int                  shadow_thr;
  int                  shadow_tmo;
  int                  gen_elapsed;
  logic [CHANNELS-1:0] gen_pins;
  logic [CHANNELS-1:0] gen_read;
  logic                gen_done;

  always #5 clk = ~clk;

  line_sensor_decay_steering DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_pin_levels    (in_pin_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_pattern (out_line_pattern),
    .out_steer_action (out_steer_action),
    .out_left_duty    (out_left_duty),
    .out_right_duty   (out_right_duty),
    .out_timed_out    (out_timed_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  steering_checker watch (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_pin_levels    (in_pin_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_pattern (out_line_pattern),
    .out_steer_action (out_steer_action),
    .out_left_duty    (out_left_duty),
    .out_right_duty   (out_right_duty),
    .out_timed_out    (out_timed_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .awaiting         (awaiting)
  );

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rst_n && idle_on && !quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken,
  // leaving in_valid high so the next call either replaces or lowers it.
  task automatic push_word(logic [1:0] op, logic [CHANNELS-1:0] pins);
    if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_pin_levels <= pins;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    word_count++;
    if (word_count > RANDOM_WORDS - 150) quiet <= 1'b1;
  endtask

  task automatic set_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(int thr, int tmo, int base, int gentle, int sharp);
    logic [7:0] junk;
    set_reg(REG_LIGHT_THRESHOLD, thr[15:0]);
    set_reg(REG_TIMEOUT_COUNT, tmo[15:0]);
    junk = 8'($urandom);
    set_reg(REG_BASE_SPEED, {junk, base[7:0]});
    junk = 8'($urandom);
    set_reg(REG_GENTLE_OFFSET, {junk, gentle[7:0]});
    junk = 8'($urandom);
    set_reg(REG_SHARP_OFFSET, {junk, sharp[7:0]});
    shadow_thr = thr;
    shadow_tmo = tmo;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (awaiting != 0 && waited < 500) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic gen_tick();
    push_word(OP_TICK, CHANNELS'($urandom));
    if (gen_elapsed < 65535) gen_elapsed++;
    if (gen_elapsed >= shadow_tmo) gen_done = 1'b1;
  endtask

  task automatic gen_toggle(logic [CHANNELS-1:0] flip);
    gen_pins = gen_pins ^ flip;
    gen_read = gen_read | flip;
    push_word(OP_SAMPLE, gen_pins);
    if (gen_read == CHAN_ALL) gen_done = 1'b1;
  endtask

  // Light channels decay before the threshold, dark ones after it or never.
  task automatic run_measurement(logic [CHANNELS-1:0] light, logic by_timeout);
    logic [CHANNELS-1:0] remaining;
    logic [CHANNELS-1:0] part;
    push_word(OP_START, CHANNELS'($urandom));
    gen_elapsed = 0;
    gen_pins = CHAN_ALL;
    gen_read = '0;
    gen_done = 1'b0;
    if (shadow_thr == 0) light = '0;
    if (shadow_thr > 1000) light = CHAN_ALL;
    if (shadow_tmo > 1000) by_timeout = 1'b0;
    remaining = light;
    while (remaining != 0 && !gen_done) begin
      if (gen_elapsed + 1 < shadow_thr && $urandom_range(0, 2) == 0) begin
        gen_tick();
      end else if ($urandom_range(0, 5) == 0) begin
        gen_toggle(gen_read & light & CHANNELS'($urandom));
      end else begin
        part = remaining & CHANNELS'($urandom);
        if (part == 0) part = remaining;
        remaining = remaining & ~part;
        gen_toggle(part);
      end
    end
    while (!gen_done && gen_elapsed < shadow_thr) gen_tick();
    remaining = CHAN_ALL & ~gen_read;
    if (by_timeout) begin
      part = remaining & CHANNELS'($urandom);
      if (!gen_done && part != remaining && part != 0) gen_toggle(part);
      while (!gen_done) gen_tick();
    end else begin
      while (!gen_done) begin
        if (gen_elapsed + 1 < shadow_tmo && $urandom_range(0, 2) == 0) begin
          gen_tick();
        end else begin
          part = remaining & CHANNELS'($urandom);
          if (part == 0) part = remaining;
          remaining = remaining & ~part;
          gen_toggle(part);
        end
      end
    end
  endtask

  task automatic run_noise(int count);
    logic [1:0] op;
    push_word(OP_START, CHANNELS'($urandom));
    repeat (count) begin
      case ($urandom_range(0, 19))
        0:       op = OP_START;
        1:       op = OP_UNUSED;
        2, 3, 4, 5, 6, 7, 8, 9: op = OP_TICK;
        default: op = OP_SAMPLE;
      endcase
      push_word(op, CHANNELS'($urandom));
    end
  endtask

  function automatic logic [CHANNELS-1:0] pick_pattern();
    case ($urandom_range(0, 4))
      0:       return PAT_RIGHT;
      1:       return PAT_SLIGHT_RIGHT;
      2:       return PAT_LEFT;
      3:       return PAT_SLIGHT_LEFT;
      default: return PAT_STRAIGHT;
    endcase
  endfunction

  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int phase;
    int pick;
    shadow_thr = int'(RST_LIGHT_THRESHOLD);
    shadow_tmo = int'(RST_TIMEOUT_COUNT);
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle words are ignored, a start while busy restarts the measurement.
    push_word(OP_TICK, 5'b00000);
    push_word(OP_SAMPLE, 5'b10101);
    push_word(OP_UNUSED, 5'b11111);
    push_word(OP_START, 5'b00000);
    push_word(OP_UNUSED, 5'b00000);
    push_word(OP_SAMPLE, 5'b00000);
    push_word(OP_START, 5'b11111);
    push_word(OP_SAMPLE, 5'b11111);
    push_word(OP_START, 5'b01010);
    push_word(OP_SAMPLE, 5'b01010);
    run_measurement(PAT_STRAIGHT, 1'b0);
    drain();
    set_reg(REG_NONE, 16'hFFFF);
    configure(3, 8, 100, 20, 60);
    run_measurement(PAT_RIGHT, 1'b0);
    run_measurement(PAT_SLIGHT_RIGHT, 1'b0);
    run_measurement(PAT_LEFT, 1'b0);
    run_measurement(PAT_SLIGHT_LEFT, 1'b0);
    run_measurement(PAT_STRAIGHT, 1'b0);
    run_measurement(PAT_LEFT, 1'b1);
    drain();
    configure(0, 0, 255, 1, 0);
    run_measurement(5'b00000, 1'b0);
    run_measurement(5'b00000, 1'b1);
    drain();

    phase = 0;
    while (word_count < RANDOM_WORDS) begin
      case (phase)
        0:       configure(0, 1, 0, 255, 255);
        1:       configure(65535, 65535, 255, 255, 255);
        2:       configure(1, 65535, 255, 0, 1);
        3:       configure(12, 3, 128, 127, 128);
        default: configure($urandom_range(1, 10), $urandom_range(1, 24),
                           $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
      endcase
      idle_on <= ($urandom_range(0, 3) != 0);
      repeat (8) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          run_noise($urandom_range(1, 12));
        end else if (pick < 6) begin
          run_measurement(pick_pattern(), $urandom_range(0, 3) == 0);
        end else begin
          run_measurement(CHANNELS'($urandom), $urandom_range(0, 3) == 0);
        end
      end
      push_word(OP_START, CHANNELS'($urandom));
      push_word(OP_SAMPLE, 5'b00000);
      drain();
      phase++;
    end

    drain();
    if (mismatches == 0 && awaiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
